### sv/plti_pkg.sv
package plti_pkg;

    // default sizes of the table and the sample format
    localparam int MAX_ROWS_DEF     = 64;
    localparam int NUM_CHANNELS_DEF = 10;
    localparam int SAMPLE_BITS_DEF  = 16;

    // fixed field widths
    localparam int CMD_W      = 2;
    localparam int CH_W       = 4;
    localparam int ROW_W      = 6;
    localparam int ROWS_CFG_W = 7;

    // depth of the queue between front and engine, a power of two
    localparam int QUEUE_DEPTH = 4;

    // command codes, also used as the kind of a queued operation
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_AXIS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OUT    = 2'd2;

    // row count after reset
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd2;

    // queue status seen by the front and the engine
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### sv/piecewise_linear_table_interpolator_top.sv
// Piecewise linear table interpolator, several channels.
// Input stream (s_axis): tuser carries the command (sample, axis write,
// output write); tdata carries channel, row and value. Load beats write the
// shared axis column or one channel's output column and give no result.
// A sample beat gives one beat on m_axis: channel and interpolated value.
// Unused commands, bad channels and rows past the table are taken and dropped.
// The row count is written through the cfg channel (always ready) between
// runs; values outside 2..MAX_ROWS are clamped.
// Sequence: a load is written from the queue head in the engine's idle state.
// A sample hitting an end of the table reads both end rows and returns that
// end's output entry; an inner sample scans the axis memory downward for its
// segment, reads both output entries, multiplies and runs a bit-serial divider.
// A four-beat queue parts intake from the engine, so s_axis keeps taking
// beats while a sample is worked on or while a result waits in the output
// register. A stalled m_axis holds the result and the engine; the queue then
// fills and s_axis_tready drops. Reset empties queue and output register and
// sets the row count to 2; table contents are undefined until written.
module piecewise_linear_table_interpolator_top #(
    parameter int MAX_ROWS     = plti_pkg::MAX_ROWS_DEF,
    parameter int NUM_CHANNELS = plti_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = plti_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // channel, row, value (from bit 0 up), zero padded to bytes
    input  logic [((plti_pkg::CH_W + plti_pkg::ROW_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                                    s_axis_tdata,
    // cmd
    input  logic [plti_pkg::CMD_W-1:0]              s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // out_channel, result_value (from bit 0 up), zero padded to bytes
    output logic [((plti_pkg::CH_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                                    m_axis_tdata,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [plti_pkg::ROWS_CFG_W-1:0]         i_cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CH_W   = plti_pkg::CH_W;
    localparam int ROW_W  = plti_pkg::ROW_W;
    localparam int CMD_W  = plti_pkg::CMD_W;
    localparam int OUT_W  = ((CH_W + SB + 7) / 8) * 8;
    localparam int Q_W    = CMD_W + CH_W + RW + SB;

    logic                  w_push;
    logic [CMD_W-1:0]      w_f_kind;
    logic [CH_W-1:0]       w_f_ch;
    logic [RW-1:0]         w_f_row;
    logic signed [SB-1:0]  w_f_val;
    logic [Q_W-1:0]        w_q_in;
    logic [Q_W-1:0]        w_q_out;
    plti_pkg::t_q_stat     w_q_stat;
    logic                  w_pop;
    logic [CH_W-1:0]       w_res_ch;
    logic signed [SB-1:0]  w_res_val;

    // intake and classification
    plti_front #(
        .MAX_ROWS     (MAX_ROWS),
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_cmd     (s_axis_tuser),
        .i_channel (s_axis_tdata[CH_W-1:0]),
        .i_row     (s_axis_tdata[CH_W+ROW_W-1:CH_W]),
        .i_value   (s_axis_tdata[CH_W+ROW_W+SB-1:CH_W+ROW_W]),
        .i_q_stat  (w_q_stat),
        .o_push    (w_push),
        .o_kind    (w_f_kind),
        .o_channel (w_f_ch),
        .o_row     (w_f_row),
        .o_value   (w_f_val)
    );

    // queue between front and engine
    assign w_q_in = {w_f_kind, w_f_ch, w_f_row, w_f_val};

    plti_fifo #(
        .DATA_W (Q_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_stat  (w_q_stat)
    );

    // table engine
    plti_engine #(
        .MAX_ROWS     (MAX_ROWS),
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_rows   (i_cfg_data),
        .i_q_stat     (w_q_stat),
        .o_pop        (w_pop),
        .i_op_kind    (w_q_out[Q_W-1:Q_W-CMD_W]),
        .i_op_channel (w_q_out[SB+RW+CH_W-1:SB+RW]),
        .i_op_row     (w_q_out[SB+RW-1:SB]),
        .i_op_value   (w_q_out[SB-1:0]),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_channel    (w_res_ch),
        .o_value      (w_res_val)
    );

    assign m_axis_tdata = OUT_W'({w_res_val, w_res_ch});
    assign o_cfg_ready  = 1'b1;

endmodule

### sv/plti_front.sv
module plti_front #(
    parameter int MAX_ROWS     = plti_pkg::MAX_ROWS_DEF,
    parameter int NUM_CHANNELS = plti_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = plti_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [plti_pkg::CMD_W-1:0]      i_cmd,
    input  logic [plti_pkg::CH_W-1:0]       i_channel,
    input  logic [plti_pkg::ROW_W-1:0]      i_row,
    input  logic signed [SAMPLE_BITS-1:0]   i_value,
    input  plti_pkg::t_q_stat               i_q_stat,
    output logic                            o_push,
    output logic [plti_pkg::CMD_W-1:0]      o_kind,
    output logic [plti_pkg::CH_W-1:0]       o_channel,
    output logic [$clog2(MAX_ROWS)-1:0]     o_row,
    output logic signed [SAMPLE_BITS-1:0]   o_value
);

    localparam int RW = $clog2(MAX_ROWS);

    logic w_row_ok;
    logic w_ch_ok;
    logic w_keep;

    // range checks on the addressing fields
    assign w_row_ok = 32'(i_row) < MAX_ROWS;
    assign w_ch_ok  = 32'(i_channel) < NUM_CHANNELS;

    // classify: keep only commands that do something
    always_comb begin
        case (i_cmd)
            plti_pkg::CMD_SAMPLE: w_keep = w_ch_ok;
            plti_pkg::CMD_AXIS:   w_keep = w_row_ok;
            plti_pkg::CMD_OUT:    w_keep = w_row_ok && w_ch_ok;
            default:              w_keep = 1'b0;
        endcase
    end

    // a beat is taken whenever the queue has room; dropped beats go nowhere
    assign o_ready   = !i_q_stat.full;
    assign o_push    = i_valid && !i_q_stat.full && w_keep;
    assign o_kind    = i_cmd;
    assign o_channel = i_channel;
    assign o_row     = RW'(i_row);
    assign o_value   = i_value;

endmodule

### sv/plti_fifo.sv
module plti_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output plti_pkg::t_q_stat o_stat
);

    localparam int DEPTH = plti_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW:0]       r_count;
    logic [AW:0]       n_count;

    assign o_stat.full  = r_count == (AW + 1)'(DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_data       = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers wrap naturally at a power-of-two depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW + 1)'(DEPTH))
        else $error("queue count beyond depth");

endmodule

### sv/plti_div.sv
module plti_div #(
    parameter int W = plti_pkg::SAMPLE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2*W-1:0] i_dividend,
    input  logic [W-1:0]   i_divisor,
    output logic           o_done,
    output logic [W-1:0]   o_quot
);

    // the upper half of the dividend is below the divisor, so the
    // quotient fits in W bits and W restoring steps suffice
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_q;
    logic [W-1:0]  r_div;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;
    logic          w_ge;

    // one quotient bit per cycle
    assign w_trial = {r_rem, r_q[W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = w_trial >= {1'b0, r_div};

    assign o_done = r_done;
    assign o_quot = r_q;

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[2*W-1:W];
            r_q   <= i_dividend[W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
            r_q   <= {r_q[W-2:0], w_ge};
        end
    end

endmodule

### sv/plti_engine.sv
module plti_engine #(
    parameter int MAX_ROWS     = plti_pkg::MAX_ROWS_DEF,
    parameter int NUM_CHANNELS = plti_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = plti_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [plti_pkg::ROWS_CFG_W-1:0]     i_cfg_rows,
    input  plti_pkg::t_q_stat                   i_q_stat,
    output logic                                o_pop,
    input  logic [plti_pkg::CMD_W-1:0]          i_op_kind,
    input  logic [plti_pkg::CH_W-1:0]           i_op_channel,
    input  logic [$clog2(MAX_ROWS)-1:0]         i_op_row,
    input  logic signed [SAMPLE_BITS-1:0]       i_op_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [plti_pkg::CH_W-1:0]           o_channel,
    output logic signed [SAMPLE_BITS-1:0]       o_value
);

    localparam int SB        = SAMPLE_BITS;
    localparam int RW        = $clog2(MAX_ROWS);
    localparam int OUT_DEPTH = NUM_CHANNELS * MAX_ROWS;
    localparam int OW        = $clog2(OUT_DEPTH);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FIRST  = 4'd1;
    localparam logic [3:0] ST_LAST   = 4'd2;
    localparam logic [3:0] ST_SCAN   = 4'd3;
    localparam logic [3:0] ST_END    = 4'd4;
    localparam logic [3:0] ST_OLO    = 4'd5;
    localparam logic [3:0] ST_OHI    = 4'd6;
    localparam logic [3:0] ST_MUL    = 4'd7;
    localparam logic [3:0] ST_DSTART = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    // table memories
    logic signed [SB-1:0] mem_axis [MAX_ROWS];
    logic signed [SB-1:0] mem_out  [OUT_DEPTH];
    logic signed [SB-1:0] r_ax_q;
    logic signed [SB-1:0] r_o_q;

    logic [3:0]                          r_state;
    logic [3:0]                          n_state;
    logic [plti_pkg::ROWS_CFG_W-1:0]     r_rows;
    logic [RW-1:0]                       w_last;
    logic [RW-1:0]                       r_last;
    logic [RW-1:0]                       r_idx;
    logic [plti_pkg::CH_W-1:0]           r_ch;
    logic signed [SB-1:0]                r_v;
    logic signed [SB-1:0]                r_first;
    logic signed [SB-1:0]                r_lo;
    logic signed [SB-1:0]                r_hi;
    logic signed [SB-1:0]                r_base;
    logic [SB-1:0]                       r_mag;
    logic [SB-1:0]                       r_dt;
    logic [SB-1:0]                       r_di;
    logic                                r_neg;
    logic [2*SB-1:0]                     r_prod;
    logic signed [SB-1:0]                r_res;
    logic                                r_out_valid;
    logic [plti_pkg::CH_W-1:0]           r_out_ch;
    logic signed [SB-1:0]                r_out_val;

    logic                  w_ax_we;
    logic                  w_o_we;
    logic [RW-1:0]         w_ax_raddr;
    logic [OW-1:0]         w_o_raddr;
    logic signed [SB-1:0]  w_v1;
    logic signed [SB-1:0]  w_v2;
    logic                  w_at_first;
    logic                  w_at_last;
    logic                  w_found;
    logic [SB:0]           w_do;
    logic [SB:0]           w_do_abs;
    logic [SB:0]           w_dt;
    logic [SB:0]           w_di;
    logic [SB:0]           w_sum;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [SB-1:0]         w_div_quot;
    logic                  w_out_load;

    function automatic logic [OW-1:0] f_oaddr(input logic [plti_pkg::CH_W-1:0] ch,
                                              input logic [RW-1:0] row);
        f_oaddr = OW'(32'(ch) * MAX_ROWS + 32'(row));
    endfunction

    // row count register and its clamp to the table size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= plti_pkg::ROWS_RESET;
        end else if (i_cfg_we) begin
            r_rows <= i_cfg_rows;
        end
    end

    always_comb begin
        if (r_rows < 7'd2) begin
            w_last = RW'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            w_last = RW'(MAX_ROWS - 1);
        end else begin
            w_last = RW'(r_rows - 7'd1);
        end
    end

    // queue head handling
    assign o_pop   = (r_state == ST_IDLE) && !i_q_stat.empty;
    assign w_ax_we = o_pop && (i_op_kind == plti_pkg::CMD_AXIS);
    assign w_o_we  = o_pop && (i_op_kind == plti_pkg::CMD_OUT);

    // clip to the end entries, raise first then lower
    assign w_v1       = (r_v < r_first) ? r_first : r_v;
    assign w_v2       = (w_v1 > r_ax_q) ? r_ax_q : w_v1;
    assign w_at_first = w_v2 == r_first;
    assign w_at_last  = w_v2 == r_ax_q;

    // downward scan stops at the highest row not above the sample
    assign w_found = r_ax_q <= r_v;

    // segment deltas
    assign w_do     = {r_o_q[SB-1], r_o_q} - {r_base[SB-1], r_base};
    assign w_do_abs = w_do[SB] ? (~w_do + 1'b1) : w_do;
    assign w_dt     = {r_v[SB-1], r_v} - {r_lo[SB-1], r_lo};
    assign w_di     = {r_hi[SB-1], r_hi} - {r_lo[SB-1], r_lo};
    assign w_sum    = r_neg ? ({r_base[SB-1], r_base} - {1'b0, w_div_quot})
                            : ({r_base[SB-1], r_base} + {1'b0, w_div_quot});

    // read addresses per step
    always_comb begin
        w_ax_raddr = '0;
        w_o_raddr  = f_oaddr(r_ch, r_idx);
        case (r_state)
            ST_FIRST: w_ax_raddr = r_last;
            ST_LAST: begin
                w_ax_raddr = r_last - 1'b1;
                w_o_raddr  = w_at_first ? f_oaddr(r_ch, '0) : f_oaddr(r_ch, r_last);
            end
            ST_SCAN:  w_ax_raddr = r_idx - 1'b1;
            ST_OLO:   w_o_raddr  = f_oaddr(r_ch, r_idx + 1'b1);
            default:  w_ax_raddr = '0;
        endcase
    end

    // axis column
    always_ff @(posedge i_clk) begin
        if (w_ax_we) begin
            mem_axis[i_op_row] <= i_op_value;
        end
        r_ax_q <= mem_axis[w_ax_raddr];
    end

    // output columns
    always_ff @(posedge i_clk) begin
        if (w_o_we) begin
            mem_out[f_oaddr(i_op_channel, i_op_row)] <= i_op_value;
        end
        r_o_q <= mem_out[w_o_raddr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_pop && (i_op_kind == plti_pkg::CMD_SAMPLE)) begin
                    n_state = ST_FIRST;
                end
            end
            ST_FIRST: n_state = ST_LAST;
            ST_LAST:  n_state = (w_at_first || w_at_last) ? ST_END : ST_SCAN;
            ST_SCAN:  n_state = w_found ? ST_OLO : ST_SCAN;
            ST_END:   n_state = ST_DONE;
            ST_OLO:   n_state = ST_OHI;
            ST_OHI:   n_state = ST_MUL;
            ST_MUL:   n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DIV;
            ST_DIV:   n_state = w_div_done ? ST_DONE : ST_DIV;
            ST_DONE:  n_state = w_out_load ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers of one sample
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ch   <= i_op_channel;
                r_v    <= i_op_value;
                r_last <= w_last;
            end
            ST_FIRST: r_first <= r_ax_q;
            ST_LAST: begin
                r_v   <= w_v2;
                r_hi  <= r_ax_q;
                r_idx <= w_at_first ? '0 : r_last - 1'b1;
            end
            ST_SCAN: begin
                if (w_found) begin
                    r_lo <= r_ax_q;
                end else begin
                    r_hi  <= r_ax_q;
                    r_idx <= r_idx - 1'b1;
                end
            end
            ST_END:  r_res  <= r_o_q;
            ST_OLO:  r_base <= r_o_q;
            ST_OHI: begin
                r_neg <= w_do[SB];
                r_mag <= w_do_abs[SB-1:0];
                r_dt  <= w_dt[SB-1:0];
                r_di  <= w_di[SB-1:0];
            end
            ST_MUL:  r_prod <= r_mag * r_dt;
            ST_DIV: begin
                if (w_div_done) begin
                    r_res <= w_sum[SB-1:0];
                end
            end
            default: r_prod <= r_prod;
        endcase
    end

    // scaled delta divided by the axis step
    assign w_div_start = r_state == ST_DSTART;

    plti_div #(
        .W (SB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_di),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // output register, loaded when empty or being drained
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ch  <= r_ch;
            r_out_val <= r_res;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_channel = r_out_ch;
    assign o_value   = r_out_val;

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_hi > r_v && r_idx < r_last))
        else $error("scan left its segment bounds");

    a_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OHI) |-> (r_lo <= r_v && r_v < r_hi))
        else $error("segment does not bracket the sample");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && w_div_done) |-> (w_div_quot <= r_mag))
        else $error("interpolation step exceeds the output delta");

endmodule
